// ===== rtl/pplau_pkg.sv =====
`default_nettype none
package pplau_pkg;

	// Actions carried by an input request.
	localparam logic [1:0] ACT_OPEN    = 2'd0;
	localparam logic [1:0] ACT_GET     = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;
	localparam logic [1:0] ACT_CONNECT = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_EXHAUST = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_USE_CUSTOM = 2'd0;
	localparam logic [1:0] CFG_MIN_PORT   = 2'd1;
	localparam logic [1:0] CFG_MAX_PORT   = 2'd2;

	// Default port range and lease hold time in milliseconds.
	localparam logic [15:0] DEF_MIN_PORT = 16'd49152;
	localparam logic [15:0] DEF_MAX_PORT = 16'd65534;
	localparam logic [47:0] HOLD_MS      = 48'd240000;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  session;
		logic [31:0] peer_id;
		logic [15:0] port_number;
		logic        still_connected;
		logic [47:0] now_ms;
		logic [15:0] start_port;
	} in_t;

	typedef struct packed {
		logic [15:0] granted_port;
		logic [1:0]  status;
	} out_t;

endpackage
`default_nettype wire

// ===== rtl/passive_port_lease_allocator_unit.sv =====
// Flow: an open or ignored request goes straight to the result stage; release and mark
// connected read the port row, then write it back; a get reads, then modify-writes the
// port row memory for each candidate port walked; the worst get walks the port range up
// to three times. One request at a time; the next is accepted once the result is registered.
// Reset: arst_n clears control and session state; then a clearing pass writes every port row
// before the first request is accepted. Configuration writes always go in.
`default_nettype none
module passive_port_lease_allocator_unit #(
	parameter int PORT_BITS      = 16,
	parameter int SLOTS_PER_PORT = 4,
	parameter int SESSIONS       = 16,
	parameter int LEASE_BITS     = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  pplau_pkg::in_t      in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output pplau_pkg::out_t     out_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [15:0]         cfg_data
);
	import pplau_pkg::*;

	localparam int PB = PORT_BITS;
	localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int SLW = (SLOTS_PER_PORT > 1) ? $clog2(SLOTS_PER_PORT) : 1;
	localparam logic [15:0] PortMax16 = 16'((1 << PORT_BITS) - 1);
	localparam logic [16:0] PortMax17 = 17'((1 << PORT_BITS) - 1);
	localparam logic [LEASE_BITS-1:0] LeaseMax = '1;

	typedef struct packed {
		logic                  valid;
		logic [31:0]           peer;
		logic [LEASE_BITS-1:0] leases;
		logic [47:0]           expiry;
	} slot_t;

	typedef struct packed {
		logic                             conn;
		slot_t [SLOTS_PER_PORT-1:0]       slot;
	} row_t;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_ADV  = 6'b000100,
		S_EVAL = 6'b001000,
		S_RMW  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic        use_custom_q;
	logic [15:0] min_port_q;
	logic [15:0] max_port_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_custom_q <= 1'b0;
			min_port_q   <= '0;
			max_port_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_USE_CUSTOM: use_custom_q <= cfg_data[0];
				CFG_MIN_PORT:   min_port_q   <= cfg_data;
				CFG_MAX_PORT:   max_port_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Current port range after swap, zero raise and limit to the largest port.
	logic [15:0]   ra, rb;
	logic [PB-1:0] lo, hi;

	always_comb begin
		if (use_custom_q) begin
			ra = (min_port_q > max_port_q) ? max_port_q : min_port_q;
			rb = (min_port_q > max_port_q) ? min_port_q : max_port_q;
			if (ra == 16'd0) ra = 16'd1;
			if (rb == 16'd0) rb = 16'd1;
		end else begin
			ra = DEF_MIN_PORT;
			rb = DEF_MAX_PORT;
		end
		if (ra > PortMax16) ra = PortMax16;
		if (rb > PortMax16) rb = PortMax16;
		lo = ra[PB-1:0];
		hi = rb[PB-1:0];
	end

	// Latched request.
	in_t           req_q;
	logic [SW-1:0] sidx_q;
	logic [PB-1:0] port_q;
	logic [47:0]   hold_q;
	out_t          res_q;

	logic [48:0] hold_sum;
	logic        sess_ok;
	logic        port_ok;
	logic [15:0] open_sp;

	assign hold_sum = {1'b0, in_data.now_ms} + {1'b0, HOLD_MS};
	assign sess_ok  = 32'(in_data.session) < SESSIONS;
	assign port_ok  = (in_data.port_number != 16'd0) &&
		({1'b0, in_data.port_number} <= PortMax17);

	always_comb begin
		open_sp = in_data.start_port;
		if (open_sp < 16'(lo)) open_sp = 16'(lo);
		if (open_sp > 16'(hi)) open_sp = 16'(hi);
	end

	// Session contexts.
	logic [PB-1:0] sess_cur_q [SESSIONS];
	logic [PB-1:0] sess_start_q [SESSIONS];
	logic          sess_so_q [SESSIONS];
	logic          sess_ss_q [SESSIONS];

	logic [PB-1:0] cur_s, st_s, adv_cur;
	logic          so_s, ss_s, adv_so, adv_ss, adv_exhaust;
	logic [PB:0]   nxt;

	assign cur_s = sess_cur_q[sidx_q];
	assign so_s  = sess_so_q[sidx_q];
	assign ss_s  = sess_ss_q[sidx_q];

	// Next candidate port of a get walk.
	always_comb begin
		st_s = sess_start_q[sidx_q];
		if (st_s < lo) st_s = lo;
		if (st_s > hi) st_s = hi;
		adv_so      = so_s;
		adv_ss      = ss_s;
		adv_exhaust = 1'b0;
		nxt         = {1'b0, cur_s} + {{PB{1'b0}}, 1'b1};
		if (cur_s == '0) begin
			adv_cur = st_s;
		end else begin
			if (nxt < {1'b0, lo} || nxt > {1'b0, hi}) adv_cur = lo;
			else adv_cur = nxt[PB-1:0];
			if (adv_cur == st_s) begin
				if (!so_s) adv_so = 1'b1;
				else if (!ss_s) adv_ss = 1'b1;
				else adv_exhaust = 1'b1;
			end
		end
	end

	// Port row memory.
	row_t          mem [1 << PORT_BITS];
	row_t          rd_q;
	logic          mem_we, mem_re;
	logic [PB-1:0] mem_wa, mem_ra;
	row_t          mem_wd;
	logic [PB:0]   clr_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	// Try one port for a get: prune idle expired slots, then match or take a free slot.
	row_t  ev_row;
	logic  ev_ok;
	always_comb begin
		logic found_m, found_f, any;
		logic [SLW-1:0] mi, fi;
		found_m = 1'b0;
		found_f = 1'b0;
		any     = 1'b0;
		mi      = '0;
		fi      = '0;
		ev_ok   = 1'b0;
		ev_row  = rd_q;
		for (int k = 0; k < SLOTS_PER_PORT; k++) begin
			if (rd_q.slot[k].valid && rd_q.slot[k].leases == '0 &&
			    rd_q.slot[k].expiry < req_q.now_ms)
				ev_row.slot[k].valid = 1'b0;
		end
		for (int k = 0; k < SLOTS_PER_PORT; k++) begin
			if (ev_row.slot[k].valid) begin
				any = 1'b1;
				if (!found_m && ev_row.slot[k].peer == req_q.peer_id) begin
					found_m = 1'b1;
					mi = k[$bits(mi)-1:0];
				end
			end else if (!found_f) begin
				found_f = 1'b1;
				fi = k[$bits(fi)-1:0];
			end
		end
		if (found_m) begin
			if (ss_s) begin
				if (ev_row.slot[mi].leases != LeaseMax)
					ev_row.slot[mi].leases = ev_row.slot[mi].leases + 1'b1;
				ev_row.slot[mi].expiry = hold_q;
				ev_row.conn = 1'b1;
				ev_ok = 1'b1;
			end
		end else if ((!any || so_s) && found_f) begin
			ev_row.slot[fi].valid  = 1'b1;
			ev_row.slot[fi].peer   = req_q.peer_id;
			ev_row.slot[fi].leases = LEASE_BITS'(1);
			ev_row.slot[fi].expiry = hold_q;
			ev_row.conn = 1'b1;
			ev_ok = 1'b1;
		end
		if (rd_q.conn) begin
			ev_row = rd_q;
			ev_ok  = 1'b0;
		end
	end

	// Release or mark connected on a port row.
	row_t rm_row;
	always_comb begin
		logic hit;
		hit    = 1'b0;
		rm_row = rd_q;
		if (req_q.action == ACT_RELEASE) begin
			for (int k = 0; k < SLOTS_PER_PORT; k++) begin
				if (!hit && rd_q.slot[k].valid && rd_q.slot[k].peer == req_q.peer_id) begin
					hit = 1'b1;
					if (rd_q.slot[k].leases != '0) begin
						rm_row.slot[k].leases = rd_q.slot[k].leases - 1'b1;
						rm_row.slot[k].expiry = hold_q;
					end
				end
			end
			if (!req_q.still_connected) rm_row.conn = 1'b0;
		end else begin
			rm_row.conn = 1'b0;
		end
	end

	// Memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = port_q;
		mem_wd = ev_row;
		mem_re = 1'b0;
		mem_ra = adv_cur;
		case (state_q)
			S_CLR: begin
				mem_we = !clr_q[PB];
				mem_wa = clr_q[PB-1:0];
				mem_wd = '0;
			end
			S_IDLE: begin
				mem_re = in_valid;
				mem_ra = in_data.port_number[PB-1:0];
			end
			S_ADV: begin
				mem_re = !adv_exhaust;
			end
			S_EVAL: begin
				mem_we = !rd_q.conn;
			end
			S_RMW: begin
				mem_we = 1'b1;
				mem_wd = rm_row;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < SESSIONS; i++) begin
				sess_cur_q[i]   <= '0;
				sess_start_q[i] <= '0;
				sess_so_q[i]    <= 1'b0;
				sess_ss_q[i]    <= 1'b0;
			end
		end else begin
			if (out_valid && out_ready && state_q != S_FIN) out_valid <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[PB]) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FIN;
						if (in_data.action == ACT_OPEN) begin
							if (sess_ok) begin
								sess_start_q[SW'(in_data.session)] <= open_sp[PB-1:0];
								sess_cur_q[SW'(in_data.session)]   <= '0;
								sess_so_q[SW'(in_data.session)]    <= 1'b0;
								sess_ss_q[SW'(in_data.session)]    <= 1'b0;
							end
						end else if (in_data.action == ACT_GET) begin
							if (sess_ok) state_q <= S_ADV;
						end else if (port_ok) begin
							state_q <= S_RMW;
						end
					end
				end
				S_ADV: begin
					sess_start_q[sidx_q] <= st_s;
					sess_cur_q[sidx_q]   <= adv_cur;
					sess_so_q[sidx_q]    <= adv_so;
					sess_ss_q[sidx_q]    <= adv_ss;
					state_q <= adv_exhaust ? S_FIN : S_EVAL;
				end
				S_EVAL: begin
					state_q <= ev_ok ? S_FIN : S_ADV;
				end
				S_RMW: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_q  <= in_data;
					sidx_q <= SW'(in_data.session);
					port_q <= in_data.port_number[PB-1:0];
					hold_q <= hold_sum[48] ? '1 : hold_sum[47:0];
					res_q.granted_port <= '0;
					if (in_data.action == ACT_OPEN || in_data.action == ACT_GET)
						res_q.status <= sess_ok ? ST_DONE : ST_IGNORED;
					else
						res_q.status <= port_ok ? ST_DONE : ST_IGNORED;
				end
			end
			S_ADV: begin
				port_q <= adv_cur;
				if (adv_exhaust) res_q.status <= ST_EXHAUST;
			end
			S_EVAL: begin
				if (ev_ok) res_q.granted_port <= 16'(port_q);
			end
			S_FIN: begin
				if (!out_valid || out_ready) out_data <= res_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/pplau_checker.sv =====
`default_nettype none
module pplau_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire              out_valid,
	input wire              out_ready,
	input pplau_pkg::out_t  out_data,
	input wire              cfg_ready
);
	import pplau_pkg::*;

	// A waiting result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One request at a time: acceptance closes the input for the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	// An exhausted or ignored request never grants a port.
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_DONE |-> out_data.granted_port == 16'd0)
		else $error("port granted with a failing status");

	// Status is one of the three defined codes.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == ST_DONE || out_data.status == ST_EXHAUST ||
			out_data.status == ST_IGNORED)
		else $error("undefined status code");

	// Configuration writes are always taken.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind passive_port_lease_allocator_unit pplau_checker u_pplau_checker (.*);
`default_nettype wire

// ===== sim/passive_port_lease_allocator_unit_tb.sv =====
`default_nettype none
module passive_port_lease_allocator_unit_tb;
	import pplau_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	passive_port_lease_allocator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the allocator: configuration, sessions and the port slot store.
	bit          cfg_custom;
	int          cfg_lo_raw;
	int          cfg_hi_raw;
	int          sess_cursor [16];
	int          sess_first [16];
	bit          sess_share_other [16];
	bit          sess_share_same [16];
	bit          port_busy [int];
	bit          slot_live [int];
	logic [31:0] slot_owner [int];
	int          slot_count [int];
	logic [47:0] slot_expire [int];
	int          recent_ports [$];

	out_t        pending_results [$];
	int          errors;
	int          n_requests, n_grants, n_exhausted, n_ignored, n_cfg;
	int          idle_mode;
	int          hold_cycles;
	logic [47:0] tick;
	logic [31:0] peers [6];

	typedef struct {
		in_t  req;
		bit   typed;
		out_t want;
	} dir_row_t;
	dir_row_t directed [$];

	// Clock and the run limit.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#360000000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report(input string msg);
		if (errors < 30)
			$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void port_bounds(output int lo, output int hi);
		int a, b, t;
		if (cfg_custom) begin
			a = cfg_lo_raw;
			b = cfg_hi_raw;
			if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
			if (a == 0) a = 1;
			if (b == 0) b = 1;
		end else begin
			a = DEF_MIN_PORT;
			b = DEF_MAX_PORT;
		end
		lo = a;
		hi = b;
	endfunction

	function automatic logic [47:0] hold_until(input logic [47:0] now);
		logic [48:0] e;
		e = {1'b0, now} + {1'b0, HOLD_MS};
		return e[48] ? 48'hFFFF_FFFF_FFFF : e[47:0];
	endfunction

	function automatic bit live(input int i);
		return slot_live.exists(i) && slot_live[i];
	endfunction

	// Tries to lease one port; prunes idle expired entries first.
	function automatic bit claim_port(input int p, input int s, input logic [31:0] peer,
			input logic [47:0] now);
		int base, hit, freek, i;
		bit any;
		base = p * 4;
		hit = -1;
		freek = -1;
		any = 1'b0;
		if (port_busy.exists(p) && port_busy[p])
			return 1'b0;
		for (int k = 0; k < 4; k++) begin
			i = base + k;
			if (live(i) && slot_count[i] == 0 && slot_expire[i] < now)
				slot_live[i] = 1'b0;
		end
		for (int k = 0; k < 4; k++) begin
			i = base + k;
			if (live(i)) begin
				any = 1'b1;
				if (hit < 0 && slot_owner[i] == peer)
					hit = k;
			end else if (freek < 0) begin
				freek = k;
			end
		end
		if (hit >= 0) begin
			if (!sess_share_same[s])
				return 1'b0;
			i = base + hit;
			if (slot_count[i] < 255)
				slot_count[i]++;
			slot_expire[i] = hold_until(now);
			port_busy[p] = 1'b1;
			return 1'b1;
		end
		if ((!any || sess_share_other[s]) && freek >= 0) begin
			i = base + freek;
			slot_live[i] = 1'b1;
			slot_owner[i] = peer;
			slot_count[i] = 1;
			slot_expire[i] = hold_until(now);
			port_busy[p] = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Cyclic walk from the cursor; each return to the start loosens sharing once.
	function automatic int walk_get(input int s, input logic [31:0] peer,
			input logic [47:0] now);
		int lo, hi, cur;
		port_bounds(lo, hi);
		if (sess_first[s] < lo) sess_first[s] = lo;
		if (sess_first[s] > hi) sess_first[s] = hi;
		while (1) begin
			cur = sess_cursor[s];
			if (cur == 0) begin
				cur = sess_first[s];
			end else begin
				cur++;
				if (cur < lo || cur > hi) cur = lo;
				if (cur == sess_first[s]) begin
					if (!sess_share_other[s]) begin
						sess_share_other[s] = 1'b1;
					end else if (!sess_share_same[s]) begin
						sess_share_same[s] = 1'b1;
					end else begin
						sess_cursor[s] = cur;
						return 0;
					end
				end
			end
			sess_cursor[s] = cur;
			if (claim_port(cur, s, peer, now))
				return cur;
		end
		return 0;
	endfunction

	function automatic out_t lease_outcome(input in_t r);
		out_t o;
		int lo, hi, sp, g, p, i;
		o = '0;
		p = r.port_number;
		case (r.action)
			ACT_OPEN: begin
				port_bounds(lo, hi);
				sp = r.start_port;
				if (sp < lo) sp = lo;
				if (sp > hi) sp = hi;
				sess_first[r.session] = sp;
				sess_cursor[r.session] = 0;
				sess_share_other[r.session] = 1'b0;
				sess_share_same[r.session] = 1'b0;
				o.status = ST_DONE;
			end
			ACT_GET: begin
				g = walk_get(r.session, r.peer_id, r.now_ms);
				o.granted_port = g[15:0];
				o.status = (g != 0) ? ST_DONE : ST_EXHAUST;
				if (g != 0) begin
					n_grants++;
					recent_ports = {recent_ports, g};
					if (recent_ports.size() > 16)
						void'(recent_ports.pop_front());
				end else begin
					n_exhausted++;
				end
			end
			default: begin
				if (p == 0) begin
					o.status = ST_IGNORED;
					n_ignored++;
				end else begin
					if (r.action == ACT_RELEASE) begin
						for (int k = 0; k < 4; k++) begin
							i = p * 4 + k;
							if (live(i) && slot_owner[i] == r.peer_id) begin
								if (slot_count[i] != 0) begin
									slot_count[i]--;
									slot_expire[i] = hold_until(r.now_ms);
								end
								break;
							end
						end
						if (!r.still_connected)
							port_busy[p] = 1'b0;
					end else begin
						port_busy[p] = 1'b0;
					end
					o.status = ST_DONE;
				end
			end
		endcase
		return o;
	endfunction

	// Idle decisions for the two sides.
	function automatic bit sender_idles();
		int pct;
		pct = (idle_mode == 1) ? 47 : (idle_mode == 3) ? 24 : 0;
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic bit receiver_stalls();
		int pct;
		pct = (idle_mode == 2) ? 47 : (idle_mode == 3) ? 24 : 0;
		return $urandom_range(0, 99) < pct;
	endfunction

	// Offers one request; the expected result is queued when it is accepted.
	task automatic send_request(input in_t r, input bit typed, input out_t want);
		out_t pred;
		if (sender_idles()) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (sender_idles())
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		pred = lease_outcome(r);
		pending_results = {pending_results, (typed ? want : pred)};
		n_requests++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			CFG_USE_CUSTOM: cfg_custom = v[0];
			CFG_MIN_PORT:   cfg_lo_raw = v;
			default:        cfg_hi_raw = v;
		endcase
		n_cfg++;
	endtask

	task automatic set_range(input bit custom, input int lo, input int hi);
		cfg_write(CFG_USE_CUSTOM, {15'd0, custom});
		cfg_write(CFG_MIN_PORT, lo[15:0]);
		cfg_write(CFG_MAX_PORT, hi[15:0]);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_t make_req(input logic [1:0] act, input int s,
			input logic [31:0] peer, input int p, input bit keep,
			input logic [47:0] now, input int sp);
		in_t r;
		r.action = act;
		r.session = s[3:0];
		r.peer_id = peer;
		r.port_number = p[15:0];
		r.still_connected = keep;
		r.now_ms = now;
		r.start_port = sp[15:0];
		return r;
	endfunction

	function automatic void add_row(input in_t r, input bit typed, input int g,
			input logic [1:0] st);
		dir_row_t d;
		d.req = r;
		d.typed = typed;
		d.want.granted_port = g[15:0];
		d.want.status = st;
		directed = {directed, d};
	endfunction

	// Random request biased toward the current range and recently leased ports.
	function automatic in_t random_req(input int lo, input int hi);
		in_t r;
		int roll;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(in_t)-1:0];
		roll = $urandom_range(0, 99);
		r.action = (roll < 12) ? ACT_OPEN : (roll < 55) ? ACT_GET :
			(roll < 80) ? ACT_RELEASE : ACT_CONNECT;
		r.session = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(0, 2));
		if ($urandom_range(0, 9) != 0)
			r.peer_id = peers[$urandom_range(0, 5)];
		roll = $urandom_range(0, 99);
		if (roll < 60 && recent_ports.size() != 0)
			r.port_number = 16'(recent_ports[$urandom_range(0, recent_ports.size() - 1)]);
		else if (roll < 80)
			r.port_number = 16'($urandom_range(lo, hi));
		else if (roll < 85)
			r.port_number = '0;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			tick = 48'({$urandom, $urandom});
		else if (roll < 3)
			tick = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 300000));
		else if (roll < 10)
			tick = tick + 48'd300000;
		else
			tick = tick + 48'($urandom_range(0, 30000));
		r.now_ms = tick;
		if ($urandom_range(0, 1) != 0)
			r.start_port = 16'($urandom_range(lo, hi));
		return r;
	endfunction

	// Receiver: random stalls, plus a long hold-off counted here.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= !receiver_stalls();
		end
	end

	// Results are taken at the edge that follows a low clock phase with both sides high.
	always @(negedge clk) begin
		out_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d/%0d with nothing pending",
					out_data.granted_port, out_data.status));
			end else begin
				w = pending_results.pop_front();
				if (out_data.granted_port !== w.granted_port)
					report($sformatf("granted_port %0d, expected %0d",
						out_data.granted_port, w.granted_port));
				if (out_data.status !== w.status)
					report($sformatf("status %0d, expected %0d", out_data.status, w.status));
			end
		end
	end

	initial begin
		int lo, hi, count;
		int ph_custom [9] = '{1, 1, 1, 1, 1, 0, 1, 1, 1};
		int ph_min [9] = '{1000, 2063, 0, 0, 65535, 40000, 500, 65535, 4};
		int ph_max [9] = '{1031, 2048, 0, 7, 65528, 40010, 540, 0, 4};
		logic [31:0] sat_peer;
		in_t r;
		out_t none;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_USE_CUSTOM;
		cfg_data = '0;
		out_ready = 1'b0;
		hold_cycles = 0;
		idle_mode = 0;
		tick = 48'd5000;
		none = '0;
		peers[0] = 32'd0;
		peers[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 6; i++)
			peers[i] = $urandom;
		for (int s = 0; s < 16; s++) begin
			sess_cursor[s] = 0;
			sess_first[s] = 0;
			sess_share_other[s] = 1'b0;
			sess_share_same[s] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_range(1'b0, 0, 0);

		// Directed part: default range, invalid ports, extremes of time and peer.
		add_row(make_req(ACT_OPEN, 0, 32'h1, 7, 0, 48'd0, 0), 1, 0, ST_DONE);
		add_row(make_req(ACT_GET, 0, peers[2], 0, 0, 48'd1000, 0), 1, 49152, ST_DONE);
		add_row(make_req(ACT_RELEASE, 0, peers[2], 0, 0, 48'd1000, 0), 1, 0, ST_IGNORED);
		add_row(make_req(ACT_CONNECT, 0, peers[2], 0, 1, 48'd1000, 0), 1, 0, ST_IGNORED);
		add_row(make_req(ACT_GET, 0, peers[2], 0, 0, 48'd2000, 0), 0, 0, ST_DONE);
		add_row(make_req(ACT_CONNECT, 0, 32'h0, 49152, 0, 48'd2000, 0), 1, 0, ST_DONE);
		add_row(make_req(ACT_RELEASE, 0, peers[2], 49153, 1, 48'd2500, 0), 1, 0, ST_DONE);
		add_row(make_req(ACT_RELEASE, 0, peers[3], 65535, 0, 48'd2500, 0), 1, 0, ST_DONE);
		add_row(make_req(ACT_OPEN, 15, 32'h0, 0, 0, 48'd0, 65535), 1, 0, ST_DONE);
		add_row(make_req(ACT_GET, 15, 32'hFFFF_FFFF, 0, 0, 48'hFFFF_FFFF_FFFF, 0), 0, 0, 0);
		add_row(make_req(ACT_GET, 15, 32'hFFFF_FFFF, 0, 0, 48'hFFFF_FFFF_FFFF, 0), 0, 0, 0);
		add_row(make_req(ACT_RELEASE, 15, 32'hFFFF_FFFF, 65534, 0,
			48'hFFFF_FFFF_FFF0, 0), 0, 0, 0);
		add_row(make_req(ACT_RELEASE, 15, 32'hFFFF_FFFF, 65534, 0,
			48'hFFFF_FFFF_FFF0, 0), 0, 0, 0);
		add_row(make_req(ACT_OPEN, 3, 32'h0, 0, 0, 48'd0, 49152), 1, 0, ST_DONE);
		add_row(make_req(ACT_GET, 3, peers[2], 0, 0, 48'd3000, 0), 0, 0, 0);
		add_row(make_req(ACT_CONNECT, 3, 32'h0, 65535, 0, 48'd3000, 0), 1, 0, ST_DONE);
		add_row(make_req(ACT_GET, 0, peers[3], 0, 1, 48'd900000, 0), 0, 0, 0);
		foreach (directed[i])
			send_request(directed[i].req, directed[i].typed, directed[i].want);
		drain();

		// One port shared by one peer over and over: the lease count saturates.
		set_range(1'b1, 300, 300);
		sat_peer = $urandom;
		for (int n = 0; n < 256; n++) begin
			send_request(make_req(ACT_OPEN, 5, sat_peer, 0, 0, tick, $urandom), 0, none);
			send_request(make_req(ACT_GET, 5, sat_peer, 0, 0, tick, 0), 0, none);
			send_request(make_req(ACT_CONNECT, 5, sat_peer, 300, 0, tick, 0), 0, none);
		end
		for (int n = 0; n < 3; n++)
			send_request(make_req(ACT_RELEASE, 5, sat_peer, 300, 0, tick, 0), 0, none);
		drain();

		// Random phases over several ranges and idle patterns.
		for (int ph = 0; ph < 9; ph++) begin
			set_range(ph_custom[ph][0], ph_min[ph], ph_max[ph]);
			idle_mode = ph % 4;
			port_bounds(lo, hi);
			count = (ph == 7) ? 12 : (ph == 5) ? 10 : 18;
			for (int n = 0; n < count; n++) begin
				r = random_req(lo, hi);
				if (ph == 7 && r.action == ACT_GET)
					r.session = 8;
				send_request(r, 0, none);
				if (ph == 1 && n == 10) begin
					@(negedge clk);
					hold_cycles = 400;
					@(posedge clk);
				end
			end
			drain();
		end
		repeat (40) @(posedge clk);

		$display("Covered %0d requests: %0d grants, %0d exhausted gets, %0d ignored.",
			n_requests, n_grants, n_exhausted, n_ignored);
		$display("Range settings written %0d times, including reversed, zero and top bounds.",
			n_cfg);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
`default_nettype wire
